// ===== rtl/etl_pkg.sv =====
// Shared types, constants and helper functions for the expression token lexer.
package etl_pkg;

  // Identifier characters kept per token and derived widths
  localparam int NameChars = 8;
  localparam int NameBits  = 64;
  localparam int ValueBits = 31;
  localparam logic [ValueBits-1:0] ValueMax = {ValueBits{1'b1}};
  localparam logic [7:0] LengthMax = 8'hFF;

  // Result queue geometry
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = QueuePtrW + 1;

  // Keyword slots in the match vector
  localparam logic [1:0] KwExit  = 2'd0;
  localparam logic [1:0] KwWhile = 2'd1;
  localparam logic [1:0] KwIf    = 2'd2;
  localparam int KwCount = 3;

  typedef enum logic [4:0] {
    TK_END      = 5'd0,
    TK_SEMI     = 5'd1,
    TK_PLUS     = 5'd2,
    TK_MINUS    = 5'd3,
    TK_STAR     = 5'd4,
    TK_MODULO   = 5'd5,
    TK_SLASH    = 5'd6,
    TK_LPAREN   = 5'd7,
    TK_RPAREN   = 5'd8,
    TK_NUMBER   = 5'd9,
    TK_IDENT    = 5'd10,
    TK_EXIT     = 5'd11,
    TK_WHILE    = 5'd12,
    TK_IF       = 5'd13,
    TK_ASSIGN   = 5'd14,
    TK_EQ       = 5'd15,
    TK_LT       = 5'd16,
    TK_LE       = 5'd17,
    TK_GT       = 5'd18,
    TK_GE       = 5'd19,
    TK_NOT      = 5'd20,
    TK_NE       = 5'd21,
    TK_UNKNOWN  = 5'd22
  } token_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_NUMBER = 3'd1,
    MODE_IDENT  = 3'd2,
    MODE_ASSIGN = 3'd3,
    MODE_LT     = 3'd4,
    MODE_GT     = 3'd5,
    MODE_NOT    = 3'd6
  } pending_mode_t;

  typedef struct packed {
    token_kind_t           kind;
    logic [ValueBits-1:0]  value;
    logic [NameBits-1:0]   chars;
    logic [7:0]            length;
    logic                  truncated;
    logic                  overflow;
    logic                  last;
  } token_t;

  // Up to two tokens pushed per accepted byte
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  function automatic token_t simple_token(input token_kind_t kind);
    token_t t;
    t = '0;
    t.kind = kind;
    return t;
  endfunction

  function automatic logic is_dec_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_name(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic [7:0] kw_len(input logic [1:0] k);
    logic [7:0] len;
    case (k)
      KwExit:  len = 8'd4;
      KwWhile: len = 8'd5;
      KwIf:    len = 8'd2;
      default: len = 8'd0;
    endcase
    return len;
  endfunction

  // Character p of keyword k; only meaningful below kw_len(k)
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      KwExit: begin
        case (p)
          3'd0:    ch = "e";
          3'd1:    ch = "x";
          3'd2:    ch = "i";
          3'd3:    ch = "t";
          default: ch = 8'h00;
        endcase
      end
      KwWhile: begin
        case (p)
          3'd0:    ch = "w";
          3'd1:    ch = "h";
          3'd2:    ch = "i";
          3'd3:    ch = "l";
          3'd4:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      KwIf: begin
        case (p)
          3'd0:    ch = "i";
          3'd1:    ch = "f";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/etl_byte_if.sv =====
// Input channel carrying one source byte per request.
interface etl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// ===== rtl/etl_token_if.sv =====
// Output channel carrying one token per request.
interface etl_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [30:0] number_value;
  logic [63:0] name_chars;
  logic [7:0]  name_length;
  logic        name_truncated;
  logic        value_overflow;
  logic        last_of_run;

  modport source (output valid, output token_kind, output number_value, output name_chars,
                  output name_length, output name_truncated, output value_overflow,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input number_value, input name_chars,
                  input name_length, input name_truncated, input value_overflow,
                  input last_of_run, output ready);
endinterface

// ===== rtl/etl_front.sv =====
// Front end: accepts bytes, tracks the pending token and classifies each byte.
module etl_front
  import etl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  etl_byte_if.sink     text_in,
  input  logic         space_ok,
  output push_t        push
);

  pending_mode_t        mode, mode_next;
  logic [ValueBits-1:0] acc, acc_next;
  logic                 ovf, ovf_next;
  logic [NameBits-1:0]  name_buffer, name_buffer_next;
  logic [7:0]           name_count, name_count_next;
  logic [KwCount-1:0]   kw_match, kw_match_next;

  logic [7:0]           c;
  logic                 accept;
  logic                 cont_num, cont_name, pair;
  logic                 flush_valid, char_valid;
  token_t               flush_tok, char_tok, pair_tok;
  token_kind_t          char_kind, ident_kind;
  pending_mode_t        char_mode;

  logic [NameBits-1:0]  base_buf, add_buf;
  logic [7:0]           base_cnt, add_cnt;
  logic [KwCount-1:0]   base_kw, add_kw;
  logic [ValueBits-1:0] base_acc, add_acc;
  logic [ValueBits+3:0] prod;
  logic                 add_sat;

  assign c      = text_in.text_byte;
  assign accept = text_in.valid && space_ok;
  assign text_in.ready = space_ok;

  assign cont_num  = (mode == MODE_NUMBER) && is_dec_digit(c);
  assign cont_name = (mode == MODE_IDENT) && is_name(c);
  assign pair      = (mode inside {MODE_ASSIGN, MODE_LT, MODE_GT, MODE_NOT}) && (c == "=");

  // Identifier extension: start from a clean buffer unless continuing
  always_comb begin
    base_buf = cont_name ? name_buffer : '0;
    base_cnt = cont_name ? name_count : 8'd0;
    base_kw  = cont_name ? kw_match : {KwCount{1'b1}};
    add_kw   = base_kw;
    for (int k = 0; k < KwCount; k++) begin
      if (!((base_cnt < kw_len(k[1:0])) && (kw_char(k[1:0], base_cnt[2:0]) == c)))
        add_kw[k] = 1'b0;
    end
    add_buf = base_buf;
    for (int i = 0; i < NameChars; i++) begin
      if (base_cnt == 8'(i))
        add_buf[8*i +: 8] = c;
    end
    add_cnt = (base_cnt == LengthMax) ? LengthMax : base_cnt + 8'd1;
  end

  // Decimal accumulate: acc * 10 + digit via shifts, saturating
  always_comb begin
    base_acc = cont_num ? acc : '0;
    prod = ({4'b0, base_acc} << 3) + ({4'b0, base_acc} << 1)
         + {{ValueBits{1'b0}}, c[3:0]};
    add_sat = (prod > {4'b0, ValueMax});
    add_acc = add_sat ? ValueMax : prod[ValueBits-1:0];
  end

  // Keyword resolution of the pending identifier
  always_comb begin
    ident_kind = TK_IDENT;
    if (kw_match[KwExit] && (name_count == kw_len(KwExit)))
      ident_kind = TK_EXIT;
    else if (kw_match[KwWhile] && (name_count == kw_len(KwWhile)))
      ident_kind = TK_WHILE;
    else if (kw_match[KwIf] && (name_count == kw_len(KwIf)))
      ident_kind = TK_IF;
  end

  // Token for whatever is pending when a byte cannot extend it
  always_comb begin
    flush_valid = 1'b1;
    flush_tok   = simple_token(TK_END);
    case (mode)
      MODE_NUMBER: begin
        flush_tok       = simple_token(TK_NUMBER);
        flush_tok.value = acc;
        flush_tok.overflow = ovf;
      end
      MODE_IDENT: begin
        flush_tok           = simple_token(ident_kind);
        flush_tok.chars     = name_buffer;
        flush_tok.length    = name_count;
        flush_tok.truncated = (name_count > 8'(NameChars));
      end
      MODE_ASSIGN: flush_tok = simple_token(TK_ASSIGN);
      MODE_LT:     flush_tok = simple_token(TK_LT);
      MODE_GT:     flush_tok = simple_token(TK_GT);
      MODE_NOT:    flush_tok = simple_token(TK_NOT);
      default:     flush_valid = 1'b0;
    endcase
  end

  // Two-character operators
  always_comb begin
    case (mode)
      MODE_ASSIGN: pair_tok = simple_token(TK_EQ);
      MODE_LT:     pair_tok = simple_token(TK_LE);
      MODE_GT:     pair_tok = simple_token(TK_GE);
      default:     pair_tok = simple_token(TK_NE);
    endcase
    pair_tok.last = 1'b1;
  end

  // Classify the byte from a clean state
  always_comb begin
    char_valid = 1'b1;
    char_kind  = TK_UNKNOWN;
    char_mode  = MODE_IDLE;
    case (c)
      8'h00: char_kind = TK_END;
      " ", 8'h0A: char_valid = 1'b0;
      ";": char_kind = TK_SEMI;
      "+": char_kind = TK_PLUS;
      "-": char_kind = TK_MINUS;
      "*": char_kind = TK_STAR;
      "%": char_kind = TK_MODULO;
      "/": char_kind = TK_SLASH;
      "(": char_kind = TK_LPAREN;
      ")": char_kind = TK_RPAREN;
      "=": begin char_valid = 1'b0; char_mode = MODE_ASSIGN; end
      "<": begin char_valid = 1'b0; char_mode = MODE_LT; end
      ">": begin char_valid = 1'b0; char_mode = MODE_GT; end
      "!": begin char_valid = 1'b0; char_mode = MODE_NOT; end
      default: begin
        if (is_dec_digit(c)) begin
          char_valid = 1'b0;
          char_mode  = MODE_NUMBER;
        end else if (is_name(c)) begin
          char_valid = 1'b0;
          char_mode  = MODE_IDENT;
        end
      end
    endcase
    char_tok = simple_token(char_kind);
  end

  // Next pending state and queue push
  always_comb begin
    mode_next        = mode;
    acc_next         = acc;
    ovf_next         = ovf;
    name_buffer_next = name_buffer;
    name_count_next  = name_count;
    kw_match_next    = kw_match;
    push             = '0;
    if (accept) begin
      if (cont_num) begin
        acc_next = add_acc;
        ovf_next = ovf | add_sat;
      end else if (cont_name) begin
        name_buffer_next = add_buf;
        name_count_next  = add_cnt;
        kw_match_next    = add_kw;
      end else if (pair) begin
        mode_next        = MODE_IDLE;
        acc_next         = '0;
        ovf_next         = 1'b0;
        name_buffer_next = '0;
        name_count_next  = 8'd0;
        kw_match_next    = {KwCount{1'b1}};
        push.count       = 2'd1;
        push.first       = pair_tok;
      end else begin
        mode_next        = char_mode;
        acc_next         = (char_mode == MODE_NUMBER) ? add_acc : '0;
        ovf_next         = 1'b0;
        name_buffer_next = (char_mode == MODE_IDENT) ? add_buf : '0;
        name_count_next  = (char_mode == MODE_IDENT) ? add_cnt : 8'd0;
        kw_match_next    = (char_mode == MODE_IDENT) ? add_kw : {KwCount{1'b1}};
        if (flush_valid && char_valid) begin
          push.count       = 2'd2;
          push.first       = flush_tok;
          push.second      = char_tok;
          push.second.last = 1'b1;
        end else if (flush_valid) begin
          push.count      = 2'd1;
          push.first      = flush_tok;
          push.first.last = 1'b1;
        end else if (char_valid) begin
          push.count      = 2'd1;
          push.first      = char_tok;
          push.first.last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      acc         <= '0;
      ovf         <= 1'b0;
      name_buffer <= '0;
      name_count  <= 8'd0;
      kw_match    <= {KwCount{1'b1}};
    end else begin
      mode        <= mode_next;
      acc         <= acc_next;
      ovf         <= ovf_next;
      name_buffer <= name_buffer_next;
      name_count  <= name_count_next;
      kw_match    <= kw_match_next;
    end
  end

endmodule

// ===== rtl/etl_queue.sv =====
// Short token queue between front and back; takes up to two tokens a cycle.
module etl_queue
  import etl_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  push_t  push,
  output logic   space_ok,
  output logic   head_valid,
  output token_t head,
  input  logic   pop
);

  token_t                mem [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr, wr_ptr_next;
  logic [QueuePtrW-1:0]  rd_ptr, rd_ptr_next;
  logic [QueueCntW-1:0]  count, count_next;
  logic [QueuePtrW-1:0]  wr_ptr_b;

  assign wr_ptr_b   = wr_ptr + QueuePtrW'(1);
  assign space_ok   = (count <= QueueCntW'(QueueDepth - 2));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_next = wr_ptr + QueuePtrW'(push.count);
    rd_ptr_next = pop ? rd_ptr + QueuePtrW'(1) : rd_ptr;
    count_next  = count + QueueCntW'(push.count) - QueueCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0)
      mem[wr_ptr] <= push.first;
    if (push.count == 2'd2)
      mem[wr_ptr_b] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

// ===== rtl/etl_back.sv =====
// Back end: drains the queue into the registered token output.
module etl_back
  import etl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  token_t       head,
  output logic         pop,
  etl_token_if.source  token_out
);

  logic   out_valid;
  token_t out_tok;

  // Load the output register whenever it is empty or being taken
  assign pop = head_valid && (!out_valid || token_out.ready);

  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (!out_valid || token_out.ready)
      out_valid <= head_valid;
  end

  always_ff @(posedge clk) begin
    if (pop)
      out_tok <= head;
  end

  assign token_out.valid          = out_valid;
  assign token_out.token_kind     = out_tok.kind;
  assign token_out.number_value   = out_tok.value;
  assign token_out.name_chars     = out_tok.chars;
  assign token_out.name_length    = out_tok.length;
  assign token_out.name_truncated = out_tok.truncated;
  assign token_out.value_overflow = out_tok.overflow;
  assign token_out.last_of_run    = out_tok.last;

endmodule

// ===== rtl/expression_token_lexer_core.sv =====
// Throughput: one byte per cycle while the queue has room; a byte giving two
// tokens needs one extra output slot, absorbed by the four-entry token queue.
// A token enters the queue at the edge that accepts its byte, then the output register.
// Input stalls only when the queue has fewer than two free entries.
// Reset (synchronous, rst high) clears the pending token, the queue and the output register.
// Top level of the expression token lexer.
module expression_token_lexer_core
  import etl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  etl_byte_if.sink     text_in,
  etl_token_if.source  token_out
);

  push_t  push;
  logic   space_ok;
  logic   head_valid;
  token_t head;
  logic   pop;

  etl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_in),
    .space_ok (space_ok),
    .push     (push)
  );

  etl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .space_ok   (space_ok),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  etl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .token_out  (token_out)
  );

endmodule
